@@ sv/spq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Payload structs, status codes and the controller-to-datapath command set.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int FILL_W       = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] removed_priority;
    logic [FILL_W-1:0]        fill_count;
  } spq_rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } spq_entry_t;

  // Datapath commands; exactly one per cycle.
  typedef enum logic [2:0] {
    CMD_NONE         = 3'd0,
    CMD_ENQ_START    = 3'd1,
    CMD_DEQ_START    = 3'd2,
    CMD_REJECT_EMPTY = 3'd3,
    CMD_REJECT_FULL  = 3'd4,
    CMD_SHIFT        = 3'd5,
    CMD_PLACE        = 3'd6,
    CMD_DEQ_DONE     = 3'd7
  } spq_cmd_t;

  typedef struct packed {
    logic empty;     // no entries held
    logic full;      // count at capacity
    logic lower;     // entry read has strictly lower priority than new item
    logic rem_one;   // one entry left above the hole
    logic rsp_busy;  // result register holds a transaction not taken this cycle
  } spq_stat_t;

endpackage
`default_nettype wire

@@ sv/spq_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_stream_if: valid/ready channel
// Carries one payload per transaction; source drives valid and payload.
// ----------------------------------------------------------------------------
interface spq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue: fixed-capacity priority queue, sorted ring buffer
// Usage notes:
//   req: one transaction per operation. opcode 0 enqueues item_value with
//        item_priority, opcode 1 dequeues the highest-priority entry.
//   rsp: exactly one transaction per request, in request order: status,
//        the removed entry (zero unless a dequeue succeeded), fill_count.
//   Equal priorities leave first in, first out. An enqueue on a full queue
//   is dropped (status 2); a dequeue on an empty queue reports status 1.
// Sequence (accept to result valid):
//   rejected operation: result register loaded on acceptance; dequeue:
//   S_DEQ posts the head entry; enqueue: S_CMP shifts each held entry of
//   strictly lower priority, then places the item. The insertion walk moves
//   one entry per cycle through the entry memory (one read and one write port),
//   and a new request is taken only after the current one has posted its result.
// Reset: rst (synchronous) empties the queue; memory contents are not cleared
//   and no clearing pass is needed, since only held entries are ever used.
// Stall: the result sits in an output register; while rsp is stalled no new
//   request is accepted, and a request is taken in the cycle the result leaves.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  wire logic     clk,
  input  wire logic     rst,
  spq_stream_if.sink    req,
  spq_stream_if.source  rsp
);
  import spq_pkg::*;

  spq_cmd_t  cmd;   // sequencer command to the datapath
  spq_stat_t stat;  // datapath flags back to the sequencer
  spq_req_t  req_payload;
  spq_rsp_t  rsp_payload;

  assign req_payload = req.payload;
  assign rsp.payload = rsp_payload;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req_payload.opcode),
    .req_ready  (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  spq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_payload (req_payload),
    .stat        (stat),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp_payload)
  );

endmodule
`default_nettype wire

@@ sv/spq_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dpath: entry memory, ring pointers and result register
// Entries live in a ring buffer; an enqueue walks from the tail toward the head.
// ----------------------------------------------------------------------------
module spq_dpath #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_pkg::spq_cmd_t  cmd,
  input  wire spq_pkg::spq_req_t  req_payload,
  output spq_pkg::spq_stat_t      stat,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output spq_pkg::spq_rsp_t       rsp_payload
);
  import spq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  spq_entry_t mem [CAPACITY];

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] hole;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] rem;
  spq_entry_t    item;
  spq_entry_t    rd_data;
  spq_rsp_t      result;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  spq_entry_t    wr_data;
  logic [CW-1:0] count_next;
  logic [CW+FILL_W-1:0] fill_ext;

  always_comb begin
    rd_addr = rd_ptr;
    wr_en   = 1'b0;
    wr_addr = hole;
    wr_data = item;
    unique case (cmd)
      CMD_ENQ_START: rd_addr = ptr_dec(tail);
      CMD_DEQ_START: rd_addr = head;
      CMD_SHIFT: begin
        rd_addr = ptr_dec(rd_ptr);
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      CMD_PLACE: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    count_next = count;
    if (cmd == CMD_PLACE) begin
      count_next = count + CW'(1);
    end else if (cmd == CMD_DEQ_DONE) begin
      count_next = count - CW'(1);
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd == CMD_PLACE) begin
        tail <= ptr_inc(tail);
      end
      if (cmd == CMD_DEQ_DONE) begin
        head <= ptr_inc(head);
      end
      if (cmd inside {CMD_REJECT_EMPTY, CMD_REJECT_FULL, CMD_PLACE, CMD_DEQ_DONE}) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Walk state and result payload.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_ENQ_START: begin
        item.value <= req_payload.item_value;
        item.prio  <= req_payload.item_priority;
        hole       <= tail;
        rd_ptr     <= ptr_dec(tail);
        rem        <= count;
      end
      CMD_SHIFT: begin
        hole   <= rd_ptr;
        rd_ptr <= ptr_dec(rd_ptr);
        rem    <= rem - CW'(1);
      end
      default: ;
    endcase
    case (cmd)
      CMD_REJECT_EMPTY, CMD_REJECT_FULL, CMD_PLACE: begin
        result.status           <= (cmd == CMD_REJECT_EMPTY) ? STATUS_EMPTY :
                                   (cmd == CMD_REJECT_FULL)  ? STATUS_FULL  : STATUS_DONE;
        result.removed_value    <= '0;
        result.removed_priority <= '0;
        result.fill_count       <= fill_ext[FILL_W-1:0];
      end
      CMD_DEQ_DONE: begin
        result.status           <= STATUS_DONE;
        result.removed_value    <= rd_data.value;
        result.removed_priority <= rd_data.prio;
        result.fill_count       <= fill_ext[FILL_W-1:0];
      end
      default: ;
    endcase
  end

  assign rsp_payload   = result;

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.lower    = (rd_data.prio < item.prio);
  assign stat.rem_one  = (rem == CW'(1));
  assign stat.rsp_busy = rsp_valid & ~rsp_ready;

endmodule
`default_nettype wire

@@ sv/spq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl: operation sequencer
// Accepts one request at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               req_opcode,
  output logic                    req_ready,
  input  wire spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t       cmd
);
  import spq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_PLACE = 4'b0100,
    S_DEQ   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE) && !stat.rsp_busy;
  assign accept    = req_ready && req_valid;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_opcode == OP_ENQUEUE) begin
            if (stat.full) begin
              cmd = CMD_REJECT_FULL;
            end else begin
              cmd        = CMD_ENQ_START;
              state_next = stat.empty ? S_PLACE : S_CMP;
            end
          end else begin
            if (stat.empty) begin
              cmd = CMD_REJECT_EMPTY;
            end else begin
              cmd        = CMD_DEQ_START;
              state_next = S_DEQ;
            end
          end
        end
      end
      S_CMP: begin
        if (stat.lower) begin
          cmd = CMD_SHIFT;
          if (stat.rem_one) begin
            state_next = S_PLACE;
          end
        end else begin
          cmd        = CMD_PLACE;
          state_next = S_IDLE;
        end
      end
      S_PLACE: begin
        cmd        = CMD_PLACE;
        state_next = S_IDLE;
      end
      S_DEQ: begin
        cmd        = CMD_DEQ_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
